// File: hw/rtl/slp_pkg.sv
// ----------------------------------------------------------------------------
// slp_pkg
// Shared constants and types for the isochronous slot length pacer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slp_pkg;

  localparam int FRAMES_PER_BUFFER = 4;
  localparam int SLOTS_PER_FRAME   = 8;
  localparam int NUM_SLOTS         = FRAMES_PER_BUFFER * SLOTS_PER_FRAME;
  localparam int SLOT_W            = $clog2(NUM_SLOTS);

  localparam int LEN_W    = 11;
  localparam int OFS_W    = 15;
  localparam int TOTAL_W  = 16;
  localparam int IDX_W    = 5;
  localparam int CNT_W    = 8;
  localparam int REM_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 48;

  localparam logic [CNT_W-1:0] PERIOD_RESET = 8'h50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION_IN     = 3'd0,
    REG_BYTES_EVEN       = 3'd1,
    REG_BYTES_ODD        = 3'd2,
    REG_SAMPLE_REMAINDER = 3'd3,
    REG_PACING_PERIOD    = 3'd4
  } slp_reg_idx_t;

  typedef struct packed {
    logic               direction_in;
    logic [LEN_W-1:0]   bytes_even;
    logic [LEN_W-1:0]   bytes_odd;
    logic [REM_W-1:0]   sample_remainder;
    logic [CNT_W-1:0]   pacing_period;
  } slp_cfg_t;

  typedef struct packed {
    logic               buffer_select;
    logic [IDX_W-1:0]   slot_index;
    logic [LEN_W-1:0]   transfer_length;
    logic [OFS_W-1:0]   buffer_offset;
    logic               interrupt_on_complete;
    logic [TOTAL_W-1:0] total_bytes;
    logic               last;
  } slp_desc_t;

endpackage

`default_nettype wire

// File: hw/rtl/slp_cfg.sv
// ----------------------------------------------------------------------------
// slp_cfg
// Configuration register file written through the cfg channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slp_cfg
  import slp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output slp_cfg_t                   cfg
);

  slp_cfg_t cfg_r;
  logic     wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction_in     <= 1'b0;
      cfg_r.bytes_even       <= '0;
      cfg_r.bytes_odd        <= '0;
      cfg_r.sample_remainder <= '0;
      cfg_r.pacing_period    <= PERIOD_RESET;
    end else if (wr) begin
      unique case (cfg_index)
        REG_DIRECTION_IN:     cfg_r.direction_in     <= cfg_data[0];
        REG_BYTES_EVEN:       cfg_r.bytes_even       <= cfg_data[LEN_W-1:0];
        REG_BYTES_ODD:        cfg_r.bytes_odd        <= cfg_data[LEN_W-1:0];
        REG_SAMPLE_REMAINDER: cfg_r.sample_remainder <= cfg_data[REM_W-1:0];
        REG_PACING_PERIOD:    cfg_r.pacing_period    <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/slp_gen.sv
// ----------------------------------------------------------------------------
// slp_gen
// Slot sequencer: walks the slots of one refill, computes length, offset and
// running total, and keeps the pacing countdown.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slp_gen
  import slp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire slp_cfg_t cfg,
  input  wire logic     start,
  input  wire logic     start_sel,
  input  wire logic     advance,
  output logic          busy,
  output logic          final_slot,
  output slp_desc_t     desc
);

  logic               busy_r,  busy_nxt;
  logic [SLOT_W-1:0]  slot_r,  slot_nxt;
  logic               sel_r,   sel_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0]   cnt_r,   cnt_nxt;

  logic [CNT_W-1:0]   cnt_dec;
  logic               catch_up;
  logic [LEN_W-1:0]   len;
  logic [TOTAL_W-1:0] total_sum;
  logic               step;

  assign busy       = busy_r;
  assign step       = busy_r & advance;
  assign final_slot = (slot_r == SLOT_W'(NUM_SLOTS - 1));
  assign catch_up   = {1'b0, cnt_r} < {4'b0, cfg.sample_remainder, 1'b0};
  assign cnt_dec    = cnt_r - 1'b1;
  assign total_sum  = total_r + TOTAL_W'(len);

  always_comb begin
    if (cfg.direction_in) begin
      len = cfg.bytes_even;
    end else if (slot_r[0] && !catch_up) begin
      len = cfg.bytes_odd;
    end else begin
      len = cfg.bytes_even;
    end
  end

  always_comb begin
    desc.buffer_select         = sel_r;
    desc.slot_index            = IDX_W'(slot_r);
    desc.transfer_length       = len;
    desc.buffer_offset         = total_r[OFS_W-1:0];
    desc.interrupt_on_complete = final_slot;
    desc.total_bytes           = total_sum;
    desc.last                  = final_slot;
  end

  always_comb begin
    busy_nxt  = busy_r;
    slot_nxt  = slot_r;
    sel_nxt   = sel_r;
    total_nxt = total_r;
    cnt_nxt   = cnt_r;
    if (step) begin
      slot_nxt  = slot_r + 1'b1;
      total_nxt = total_sum;
      if (final_slot) begin
        busy_nxt = 1'b0;
      end
      if (!cfg.direction_in) begin
        cnt_nxt = (cnt_dec == '0) ? cfg.pacing_period : cnt_dec;
      end
    end
    if (start) begin
      busy_nxt  = 1'b1;
      slot_nxt  = '0;
      sel_nxt   = start_sel;
      total_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      slot_r  <= '0;
      total_r <= '0;
      cnt_r   <= PERIOD_RESET;
    end else begin
      busy_r  <= busy_nxt;
      slot_r  <= slot_nxt;
      total_r <= total_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/slp_out.sv
// ----------------------------------------------------------------------------
// slp_out
// Result register: holds one descriptor until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slp_out
  import slp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire slp_desc_t desc_in,
  output logic           can_load,
  output logic           out_valid,
  input  wire logic      out_ready,
  output slp_desc_t      desc_out
);

  logic      valid_r, valid_nxt;
  slp_desc_t desc_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign desc_out  = desc_r;

  always_comb begin
    valid_nxt = valid_r;
    if (can_load) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      desc_r <= desc_in;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/isoch_slot_length_pacer_unit.sv
// ----------------------------------------------------------------------------
// isoch_slot_length_pacer_unit
// Top level: one refill request in, one slot descriptor out per slot.
// ----------------------------------------------------------------------------
// Each request on the in_ channel produces 32 slot descriptors on the out_
// channel, one per cycle while the output is not stalled. The next request
// is taken in the cycle the final descriptor of the current one enters the
// result register, so back-to-back requests stream without gaps.
// Configuration writes are taken in every cycle and should only be issued
// while idle.
`timescale 1ns / 1ps
`default_nettype none

module isoch_slot_length_pacer_unit
  import slp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [0] buffer_select
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [4:0] slot_index, [15:5] transfer_length,
                                                 // [30:16] buffer_offset,
                                                 // [31] interrupt_on_complete,
                                                 // [47:32] total_bytes
  output logic                       out_tuser,  // [0] buffer_select_out
  output logic                       out_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  slp_cfg_t  cfg;
  slp_desc_t gen_desc;
  slp_desc_t res_desc;
  logic      busy;
  logic      final_slot;
  logic      can_load;
  logic      start;

  assign in_tready = !busy || (can_load && final_slot);
  assign start     = in_tvalid && in_tready;

  slp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slp_gen u_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .start      (start),
    .start_sel  (in_tdata[0]),
    .advance    (can_load),
    .busy       (busy),
    .final_slot (final_slot),
    .desc       (gen_desc)
  );

  slp_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (busy),
    .desc_in   (gen_desc),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .desc_out  (res_desc)
  );

  assign out_tdata = {res_desc.total_bytes, res_desc.interrupt_on_complete,
                      res_desc.buffer_offset, res_desc.transfer_length,
                      res_desc.slot_index};
  assign out_tuser = res_desc.buffer_select;
  assign out_tlast = res_desc.last;

endmodule

`default_nettype wire
